// File: hw/rtl/atrp_pkg.sv
// atrp_pkg: shared constants and the arctangent table for the tilt block
// no dependencies
`timescale 1ns / 1ps
package atrp_pkg;

  // fixed-point constants of the angle datapath
  localparam int ANG_FRAC    = 30;
  localparam int ZW          = 35;
  localparam int PRE_SHIFT   = 8;
  localparam int GUARD_SHIFT = 16;
  localparam logic [15:0] MU_RESET = 16'd655;
  localparam logic signed [ZW-1:0] PI_Q30  = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HPI_Q30 = 35'sd1686629713;

  // atan(2^-i) in q30, truncated, but rounded for i = 27 to 30
  function automatic logic [31:0] atan_q30(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      24: v = 32'h0000003F;
      25: v = 32'h0000001F;
      26: v = 32'h0000000F;
      27: v = 32'h00000008;
      28: v = 32'h00000004;
      29: v = 32'h00000002;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

// File: hw/rtl/atrp_sqrt_cell.sv
// atrp_sqrt_cell: one result bit of a digit-by-digit integer square root
// standalone, chained by the top level
`timescale 1ns / 1ps
module atrp_sqrt_cell #(
  parameter int QW = 24
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*QW-1:0] rad_i,
  input  logic [QW+1:0]   rem_i,
  input  logic [QW-1:0]   root_i,
  output logic [2*QW-1:0] rad_o,
  output logic [QW+1:0]   rem_o,
  output logic [QW-1:0]   root_o
);

  logic [QW+3:0] trial;
  logic [QW+3:0] test;
  logic          ge;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    trial = {rem_i, rad_i[2*QW-1 -: 2]};
    test  = {2'b00, root_i, 2'b01};
    ge    = (trial >= test);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_o  <= rad_i << 2;
      rem_o  <= ge ? (QW+2)'(trial - test) : (QW+2)'(trial);
      root_o <= {root_i[QW-2:0], ge};
    end
  end

endmodule

// File: hw/rtl/atrp_cordic_cell.sv
// atrp_cordic_cell: one vectoring cordic micro-rotation with angle accumulate
// depends on atrp_pkg for the arctangent table
`timescale 1ns / 1ps
module atrp_cordic_cell
  import atrp_pkg::*;
#(
  parameter int XW  = 43,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ANG = ZW'(atan_q30(IDX));

  // rotate toward the x axis, clockwise when y is not negative
  always_ff @(posedge clk) begin
    if (en) begin
      if (!y_i[XW-1]) begin
        x_o <= x_i + (y_i >>> IDX);
        y_o <= y_i - (x_i >>> IDX);
        z_o <= z_i + ANG;
      end else begin
        x_o <= x_i - (y_i >>> IDX);
        y_o <= y_i + (x_i >>> IDX);
        z_o <= z_i - ANG;
      end
    end
  end

endmodule

// File: hw/rtl/accel_tilt_roll_pitch.sv
// accel_tilt_roll_pitch: roll and pitch from one three-axis accelerometer sample
// depends on atrp_pkg, atrp_sqrt_cell, atrp_cordic_cell
//
// usage
//   input channel: in_valid / in_stall with time_stamp, accel_x, accel_y, accel_z.
//   output channel: out_valid / out_stall with stamp_out, roll, pitch, degenerate.
//   a word moves at a rising edge where valid is high and stall is low.
//   mu_wr / mu_data write the q0.16 mu register (reset 655); write only while idle.
// throughput: one word per cycle unless stalled; all stages are registered cells.
// pipeline: SAMPLE_BITS + CORDIC_STAGES + 13 register stages (45 at the defaults):
//   input, square, radicand, SAMPLE_BITS+8 root cells, setup, CORDIC_STAGES
//   rotation cells, and the output register behind the rounding logic.
// stall: the chain advances only while the output register is empty or taken,
//   so in_stall follows out_stall while a finished word is held; up to the full
//   chain depth of words is held in flight.
// reset: synchronous rst empties every stage and loads mu with 655.
`timescale 1ns / 1ps
module accel_tilt_roll_pitch
  import atrp_pkg::*;
#(
  parameter int SAMPLE_BITS   = 16,
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [31:0]                  time_stamp,
  input  logic signed [SAMPLE_BITS-1:0] accel_x,
  input  logic signed [SAMPLE_BITS-1:0] accel_y,
  input  logic signed [SAMPLE_BITS-1:0] accel_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [31:0]                  stamp_out,
  output logic signed [ANGLE_BITS-1:0] roll,
  output logic signed [ANGLE_BITS-2:0] pitch,
  output logic                         degenerate,
  input  logic                         mu_wr,
  input  logic [15:0]                  mu_data
);

  localparam int S  = SAMPLE_BITS;
  localparam int QW = S + 8;
  localparam int RW = 2 * QW;
  localparam int NW = S + 9;
  localparam int XW = S + 27;
  localparam int N  = CORDIC_STAGES;
  localparam int OS = ANG_FRAC - (ANGLE_BITS - 3);
  localparam logic [ZW-1:0] HALF = ZW'(1) << (OS - 1);
  localparam logic signed [ZW-1:0] PI_OUT  = (PI_Q30 + HALF) >>> OS;
  localparam logic signed [ZW-1:0] HPI_OUT = (HPI_Q30 + HALF) >>> OS;

  typedef struct packed {
    logic [31:0]          ts;
    logic signed [NW-1:0] nr;
    logic signed [NW-1:0] np;
    logic                 azn;
    logic                 dg;
  } sq_side_t;

  typedef struct packed {
    logic [31:0]          ts;
    logic                 dg;
    logic                 ovr_r;
    logic                 ovr_p;
    logic signed [ZW-1:0] zo_r;
    logic signed [ZW-1:0] zo_p;
  } cd_side_t;

  logic adv;
  logic [15:0] mu;

  // chain moves when the output register is free or being taken
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= MU_RESET;
    end else if (mu_wr) begin
      mu <= mu_data;
    end
  end

  // input register
  logic                v1;
  logic [31:0]         ts1;
  logic signed [S-1:0] ax1, ay1, az1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      ts1 <= time_stamp;
      ax1 <= accel_x;
      ay1 <= accel_y;
      az1 <= accel_z;
    end
  end

  // squares and numerators
  logic            v2;
  logic [2*S-1:0]  ax_sq, ay_sq, az_sq;
  sq_side_t        sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      ax_sq   <= (2*S)'(ax1) * (2*S)'(ax1);
      ay_sq   <= (2*S)'(ay1) * (2*S)'(ay1);
      az_sq   <= (2*S)'(az1) * (2*S)'(az1);
      sd2.ts  <= ts1;
      sd2.nr  <= NW'(ay1) <<< PRE_SHIFT;
      sd2.np  <= -(NW'(ax1) <<< PRE_SHIFT);
      sd2.azn <= az1[S-1];
      sd2.dg  <= (ax1 == '0) && (ay1 == '0) && (az1 == '0);
    end
  end

  // radicands for both roots
  logic          v3;
  logic [RW-1:0] rad_r3, rad_p3;
  sq_side_t      sd3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      rad_r3 <= (RW'(az_sq) << GUARD_SHIFT) + RW'(mu) * RW'(ax_sq);
      rad_p3 <= (RW'(ay_sq) + RW'(az_sq)) << GUARD_SHIFT;
      sd3    <= sd2;
    end
  end

  // square root cell rows, one root bit per cell
  logic [RW-1:0]   rr_rad  [0:QW];
  logic [QW+1:0]   rr_rem  [0:QW];
  logic [QW-1:0]   rr_root [0:QW];
  logic [RW-1:0]   pr_rad  [0:QW];
  logic [QW+1:0]   pr_rem  [0:QW];
  logic [QW-1:0]   pr_root [0:QW];
  logic            sv      [0:QW];
  sq_side_t        sd      [0:QW];

  assign rr_rad[0]  = rad_r3;
  assign rr_rem[0]  = '0;
  assign rr_root[0] = '0;
  assign pr_rad[0]  = rad_p3;
  assign pr_rem[0]  = '0;
  assign pr_root[0] = '0;
  assign sv[0]      = v3;
  assign sd[0]      = sd3;

  for (genvar k = 0; k < QW; k++) begin : g_sqrt
    atrp_sqrt_cell #(.QW(QW)) u_roll_cell (
      .clk(clk), .en(adv),
      .rad_i(rr_rad[k]), .rem_i(rr_rem[k]), .root_i(rr_root[k]),
      .rad_o(rr_rad[k+1]), .rem_o(rr_rem[k+1]), .root_o(rr_root[k+1])
    );
    atrp_sqrt_cell #(.QW(QW)) u_pitch_cell (
      .clk(clk), .en(adv),
      .rad_i(pr_rad[k]), .rem_i(pr_rem[k]), .root_i(pr_root[k]),
      .rad_o(pr_rad[k+1]), .rem_o(pr_rem[k+1]), .root_o(pr_root[k+1])
    );

    // sideband follows the root cells
    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
      if (adv) begin
        sd[k+1] <= sd[k];
      end
    end
  end

  // setup: special cases, half-turn for negative accel_z, guard shift
  logic signed [XW-1:0] cx_r [0:N];
  logic signed [XW-1:0] cy_r [0:N];
  logic signed [ZW-1:0] cz_r [0:N];
  logic signed [XW-1:0] cx_p [0:N];
  logic signed [XW-1:0] cy_p [0:N];
  logic signed [ZW-1:0] cz_p [0:N];
  logic                 cv   [0:N];
  cd_side_t             cd   [0:N];

  sq_side_t             sq;
  logic [QW-1:0]        root_r, root_p;
  logic signed [NW-1:0] yr;
  logic signed [ZW-1:0] z0_r;
  logic                 ovr_r, ovr_p;
  logic signed [ZW-1:0] zo_r, zo_p;

  always_comb begin
    sq     = sd[QW];
    root_r = rr_root[QW];
    root_p = pr_root[QW];
    yr     = sq.nr;
    z0_r   = '0;
    ovr_r  = 1'b0;
    zo_r   = '0;
    if (sq.nr == '0) begin
      ovr_r = 1'b1;
      zo_r  = (sq.azn && root_r != '0) ? PI_Q30 : '0;
    end else if (root_r == '0) begin
      ovr_r = 1'b1;
      zo_r  = sq.nr[NW-1] ? -HPI_Q30 : HPI_Q30;
    end else if (sq.azn) begin
      z0_r = sq.nr[NW-1] ? -PI_Q30 : PI_Q30;
      yr   = -sq.nr;
    end
    ovr_p = 1'b0;
    zo_p  = '0;
    if (sq.np == '0) begin
      ovr_p = 1'b1;
    end else if (root_p == '0) begin
      ovr_p = 1'b1;
      zo_p  = sq.np[NW-1] ? -HPI_Q30 : HPI_Q30;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= sv[QW];
    end
    if (adv) begin
      cx_r[0]     <= XW'(root_r) << GUARD_SHIFT;
      cy_r[0]     <= XW'(yr) <<< GUARD_SHIFT;
      cz_r[0]     <= z0_r;
      cx_p[0]     <= XW'(root_p) << GUARD_SHIFT;
      cy_p[0]     <= XW'(sq.np) <<< GUARD_SHIFT;
      cz_p[0]     <= '0;
      cd[0].ts    <= sq.ts;
      cd[0].dg    <= sq.dg;
      cd[0].ovr_r <= ovr_r;
      cd[0].ovr_p <= ovr_p;
      cd[0].zo_r  <= zo_r;
      cd[0].zo_p  <= zo_p;
    end
  end

  // cordic cell rows, one micro-rotation per cell
  for (genvar i = 0; i < N; i++) begin : g_cordic
    atrp_cordic_cell #(.XW(XW), .IDX(i)) u_roll_rot (
      .clk(clk), .en(adv),
      .x_i(cx_r[i]), .y_i(cy_r[i]), .z_i(cz_r[i]),
      .x_o(cx_r[i+1]), .y_o(cy_r[i+1]), .z_o(cz_r[i+1])
    );
    atrp_cordic_cell #(.XW(XW), .IDX(i)) u_pitch_rot (
      .clk(clk), .en(adv),
      .x_i(cx_p[i]), .y_i(cy_p[i]), .z_i(cz_p[i]),
      .x_o(cx_p[i+1]), .y_o(cy_p[i+1]), .z_o(cz_p[i+1])
    );

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
      if (adv) begin
        cd[i+1] <= cd[i];
      end
    end
  end

  // round q30 half away from zero to the output format
  function automatic logic signed [ZW-1:0] to_out(input logic signed [ZW-1:0] z);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] r;
    mag = z[ZW-1] ? ZW'(-z) : ZW'(z);
    r   = (mag + HALF) >> OS;
    return z[ZW-1] ? -$signed(r) : $signed(r);
  endfunction

  logic signed [ZW-1:0] fz_r, fz_p, or_r, or_p, cl_r, cl_p;

  // final angle select, rounding and clamp
  always_comb begin
    fz_r = cd[N].ovr_r ? cd[N].zo_r : cz_r[N];
    fz_p = cd[N].ovr_p ? cd[N].zo_p : cz_p[N];
    or_r = to_out(fz_r);
    or_p = to_out(fz_p);
    cl_r = or_r;
    if (or_r > PI_OUT) begin
      cl_r = PI_OUT;
    end else if (or_r < -PI_OUT) begin
      cl_r = -PI_OUT;
    end
    cl_p = or_p;
    if (or_p > HPI_OUT) begin
      cl_p = HPI_OUT;
    end else if (or_p < -HPI_OUT) begin
      cl_p = -HPI_OUT;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= cv[N];
    end
    if (adv) begin
      stamp_out  <= cd[N].ts;
      roll       <= cl_r[ANGLE_BITS-1:0];
      pitch      <= cl_p[ANGLE_BITS-2:0];
      degenerate <= cd[N].dg;
    end
  end

  // an all-zero sample yields zero angles
  a_degen_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> roll == '0 && pitch == '0)
    else $error("degenerate word with nonzero angle");

  // roll stays within plus or minus pi
  a_roll_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> roll <= PI_OUT && roll >= -PI_OUT)
    else $error("roll out of range");

  // pitch stays within plus or minus pi/2
  a_pitch_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pitch <= HPI_OUT && pitch >= -HPI_OUT)
    else $error("pitch out of range");

  // a held word blocks the input side while it stays held
  a_hold_blocks : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> !(out_valid && out_stall) || in_stall)
    else $error("input accepted while output word held");

endmodule
